>>> rtl/symmetric_motion_gate_distance_macros.svh
// Assertion macros shared by the symmetric motion gate distance RTL.
`ifndef SYMMETRIC_MOTION_GATE_DISTANCE_MACROS_SVH
`define SYMMETRIC_MOTION_GATE_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMGD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/smgd_pkg.sv
// Package with widths, constants and types of the symmetric motion gate distance block.
package smgd_pkg;

  localparam int POSITION_WIDTH = 24;
  localparam int VELOCITY_WIDTH = 18;
  localparam int TIME_WIDTH     = 48;
  localparam int TIME_FRAC      = 16;
  localparam int DIST_WIDTH     = 26;

  localparam int DT_W    = TIME_WIDTH + 1;
  localparam int HI_W    = TIME_WIDTH - TIME_FRAC;
  localparam int PDIFF_W = POSITION_WIDTH + 1;
  localparam int PHI_W   = VELOCITY_WIDTH + HI_W;
  localparam int PLO_W   = VELOCITY_WIDTH + TIME_FRAC;
  localparam int MOT_W   = VELOCITY_WIDTH + HI_W;
  localparam int ERR_W   = MOT_W + 2;
  localparam int MAG_W   = DIST_WIDTH + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int ROOT_W  = (SUM_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;

  localparam logic [PLO_W-1:0]      ROUND_HALF = PLO_W'(1) << (TIME_FRAC - 1);
  localparam logic [ROOT_W-1:0]     GAP_CAP    = ROOT_W'(1) << MAG_W;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX   = '1;
  localparam logic [DIST_WIDTH-1:0] GATE_RESET = DIST_WIDTH'(640);

  typedef struct packed {
    logic valid;
    logic huge;
  } smgd_tag_t;

endpackage

>>> rtl/smgd_if.sv
// Valid/ready channel interfaces for track/detection pairs and gate results.
interface smgd_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [smgd_pkg::POSITION_WIDTH-1:0] track_pos_x;
  logic signed [smgd_pkg::POSITION_WIDTH-1:0] track_pos_y;
  logic signed [smgd_pkg::VELOCITY_WIDTH-1:0] track_vel_x;
  logic signed [smgd_pkg::VELOCITY_WIDTH-1:0] track_vel_y;
  logic        [smgd_pkg::TIME_WIDTH-1:0]     track_time;
  logic signed [smgd_pkg::POSITION_WIDTH-1:0] det_pos_x;
  logic signed [smgd_pkg::POSITION_WIDTH-1:0] det_pos_y;
  logic signed [smgd_pkg::VELOCITY_WIDTH-1:0] det_vel_x;
  logic signed [smgd_pkg::VELOCITY_WIDTH-1:0] det_vel_y;
  logic        [smgd_pkg::TIME_WIDTH-1:0]     frame_time;

  modport source (
    output valid, track_pos_x, track_pos_y, track_vel_x, track_vel_y, track_time,
    output det_pos_x, det_pos_y, det_vel_x, det_vel_y, frame_time,
    input  ready
  );

  modport sink (
    input  valid, track_pos_x, track_pos_y, track_vel_x, track_vel_y, track_time,
    input  det_pos_x, det_pos_y, det_vel_x, det_vel_y, frame_time,
    output ready
  );
endinterface

interface smgd_out_if;
  logic                                valid;
  logic                                ready;
  logic [smgd_pkg::DIST_WIDTH-1:0]     mean_distance;
  logic                                within_gate;

  modport source (output valid, mean_distance, within_gate, input ready);
  modport sink (input valid, mean_distance, within_gate, output ready);
endinterface

>>> rtl/smgd_sqrt.sv
// Pipelined rounded integer square root, one root bit per stage plus a rounding stage.
module smgd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  smgd_pkg::smgd_tag_t           tag_in,
  input  logic [smgd_pkg::SUM_W-1:0]    radicand,
  output smgd_pkg::smgd_tag_t           tag_out,
  output logic [smgd_pkg::ROOT_W-1:0]   root
);

  logic [smgd_pkg::RAD_W-1:0]  rad_q  [smgd_pkg::ROOT_W];
  logic [smgd_pkg::ROOT_W-1:0] root_q [smgd_pkg::ROOT_W];
  logic [smgd_pkg::REM_W-1:0]  rem_q  [smgd_pkg::ROOT_W];
  smgd_pkg::smgd_tag_t         tag_q  [smgd_pkg::ROOT_W];

  logic [smgd_pkg::RAD_W-1:0]  rad_in  [smgd_pkg::ROOT_W];
  logic [smgd_pkg::ROOT_W-1:0] root_in [smgd_pkg::ROOT_W];
  logic [smgd_pkg::REM_W-1:0]  rem_in  [smgd_pkg::ROOT_W];
  smgd_pkg::smgd_tag_t         tag_v   [smgd_pkg::ROOT_W];
  logic [smgd_pkg::REM_W-1:0]  rem_sh  [smgd_pkg::ROOT_W];
  logic [smgd_pkg::REM_W-1:0]  trial   [smgd_pkg::ROOT_W];

  logic [smgd_pkg::ROOT_W-1:0] root_fin;
  logic [smgd_pkg::REM_W-1:0]  rem_fin;

  always_comb begin
    rad_in[0]  = smgd_pkg::RAD_W'(radicand);
    root_in[0] = '0;
    rem_in[0]  = '0;
    tag_v[0]   = tag_in;
    for (int k = 1; k < smgd_pkg::ROOT_W; k++) begin
      rad_in[k]  = rad_q[k-1];
      root_in[k] = root_q[k-1];
      rem_in[k]  = rem_q[k-1];
      tag_v[k]   = tag_q[k-1];
    end
    for (int k = 0; k < smgd_pkg::ROOT_W; k++) begin
      rem_sh[k] = {rem_in[k][smgd_pkg::REM_W-3:0], rad_in[k][smgd_pkg::RAD_W-1 -: 2]};
      trial[k]  = {root_in[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < smgd_pkg::ROOT_W; k++) begin
        tag_q[k] <= '0;
      end
      tag_out <= '0;
    end else if (en) begin
      for (int k = 0; k < smgd_pkg::ROOT_W; k++) begin
        tag_q[k] <= tag_v[k];
      end
      tag_out <= tag_q[smgd_pkg::ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < smgd_pkg::ROOT_W; k++) begin
        rad_q[k] <= rad_in[k] << 2;
        if (rem_sh[k] >= trial[k]) begin
          rem_q[k]  <= rem_sh[k] - trial[k];
          root_q[k] <= {root_in[k][smgd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh[k];
          root_q[k] <= {root_in[k][smgd_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      root <= root_fin + smgd_pkg::ROOT_W'(rem_fin > smgd_pkg::REM_W'(root_fin));
    end
  end

  assign root_fin = root_q[smgd_pkg::ROOT_W-1];
  assign rem_fin  = rem_q[smgd_pkg::ROOT_W-1];

endmodule

>>> rtl/symmetric_motion_gate_distance.sv
// Top level of the symmetric motion gate distance block.
// Throughput: one pair per cycle while the skid is empty; depth is set by the 28 root-bit square-root stages.
// A two-entry output (register plus skid) keeps input ready while only one result waits.
// Reset clears all valid bits, including those of the output stage, and sets the gate to 640 (2.5 m).
`include "symmetric_motion_gate_distance_macros.svh"

module symmetric_motion_gate_distance (
  input  logic                              clk,
  input  logic                              rst,
  smgd_in_if.sink                           pair,
  smgd_out_if.source                        result,
  input  logic                              cfg_wr_en,
  input  logic [smgd_pkg::DIST_WIDTH-1:0]   cfg_wr_data
);

  logic en;

  logic [smgd_pkg::DIST_WIDTH-1:0] gate_distance;

  logic [smgd_pkg::POSITION_WIDTH-1:0] tpos [2];
  logic [smgd_pkg::POSITION_WIDTH-1:0] dpos [2];
  logic [smgd_pkg::VELOCITY_WIDTH-1:0] vel  [2][2];

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid, s8_valid;

  logic [smgd_pkg::DT_W-1:0]           s1_dt;
  logic [smgd_pkg::PDIFF_W-1:0]        s1_pd   [2];
  logic [smgd_pkg::VELOCITY_WIDTH-1:0] s1_vmag [2][2];
  logic                                s1_vneg [2][2];

  logic [smgd_pkg::TIME_WIDTH-1:0]     s2_ad;
  logic [smgd_pkg::PDIFF_W-1:0]        s2_pd   [2];
  logic [smgd_pkg::VELOCITY_WIDTH-1:0] s2_vmag [2][2];
  logic                                s2_mneg [2][2];

  logic [smgd_pkg::PHI_W-1:0]          s3_phi  [2][2];
  logic [smgd_pkg::PLO_W-1:0]          s3_plo  [2][2];
  logic [smgd_pkg::PDIFF_W-1:0]        s3_pd   [2];
  logic                                s3_mneg [2][2];

  logic [smgd_pkg::MOT_W-1:0]          s4_m    [2][2];
  logic [smgd_pkg::PDIFF_W-1:0]        s4_pd   [2];
  logic                                s4_mneg [2][2];

  logic [smgd_pkg::ERR_W-1:0]          pd_ext  [2];
  logic [smgd_pkg::ERR_W-1:0]          m_ext   [2][2];
  logic [smgd_pkg::ERR_W-1:0]          s5_err  [2][2];

  logic [smgd_pkg::ERR_W-1:0]          err_mag [2][2];
  logic [smgd_pkg::MAG_W-1:0]          s6_mag  [2][2];
  logic                                s6_huge [2];

  logic [smgd_pkg::SQ_W-1:0]           s7_sq   [2][2];
  logic                                s7_huge [2];

  logic [smgd_pkg::SUM_W-1:0]          s8_sum  [2];
  logic                                s8_huge [2];

  smgd_pkg::smgd_tag_t         fwd_in, bwd_in, fwd_tag, bwd_tag;
  logic [smgd_pkg::ROOT_W-1:0] fwd_root, bwd_root, gap_f, gap_b;
  logic [smgd_pkg::ROOT_W:0]   mean_sum;

  logic                        s38_valid;
  logic [smgd_pkg::ROOT_W-1:0] s38_mean;

  logic [smgd_pkg::DIST_WIDTH-1:0] sat_mean;
  logic                            sat_within;

  logic                            out_valid, skid_valid;
  logic [smgd_pkg::DIST_WIDTH-1:0] out_mean, skid_mean;
  logic                            out_within, skid_within;

  assign en         = !skid_valid;
  assign pair.ready = en;

  assign tpos[0]   = pair.track_pos_x;
  assign tpos[1]   = pair.track_pos_y;
  assign dpos[0]   = pair.det_pos_x;
  assign dpos[1]   = pair.det_pos_y;
  assign vel[0][0] = pair.track_vel_x;
  assign vel[0][1] = pair.track_vel_y;
  assign vel[1][0] = pair.det_vel_x;
  assign vel[1][1] = pair.det_vel_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_distance <= smgd_pkg::GATE_RESET;
    end else if (cfg_wr_en) begin
      gate_distance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      s38_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pair.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      s38_valid <= fwd_tag.valid;
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      pd_ext[a] = {{(smgd_pkg::ERR_W - smgd_pkg::PDIFF_W){s4_pd[a][smgd_pkg::PDIFF_W-1]}},
                   s4_pd[a]};
    end
    for (int g = 0; g < 2; g++) begin
      for (int a = 0; a < 2; a++) begin
        m_ext[g][a]   = smgd_pkg::ERR_W'(s4_m[g][a]);
        err_mag[g][a] = s5_err[g][a][smgd_pkg::ERR_W-1] ? ~s5_err[g][a] + 1'b1
                                                          : s5_err[g][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dt <= {1'b0, pair.frame_time} - {1'b0, pair.track_time};
      s2_ad <= s1_dt[smgd_pkg::DT_W-1] ? ~s1_dt[smgd_pkg::TIME_WIDTH-1:0] + 1'b1
                                       : s1_dt[smgd_pkg::TIME_WIDTH-1:0];
      for (int a = 0; a < 2; a++) begin
        s1_pd[a] <= {dpos[a][smgd_pkg::POSITION_WIDTH-1], dpos[a]}
                  - {tpos[a][smgd_pkg::POSITION_WIDTH-1], tpos[a]};
        s2_pd[a] <= s1_pd[a];
        s3_pd[a] <= s2_pd[a];
        s4_pd[a] <= s3_pd[a];
      end
      for (int g = 0; g < 2; g++) begin
        for (int a = 0; a < 2; a++) begin
          s1_vneg[g][a] <= vel[g][a][smgd_pkg::VELOCITY_WIDTH-1];
          s1_vmag[g][a] <= vel[g][a][smgd_pkg::VELOCITY_WIDTH-1] ? ~vel[g][a] + 1'b1
                                                                  : vel[g][a];
          s2_vmag[g][a] <= s1_vmag[g][a];
          s2_mneg[g][a] <= s1_vneg[g][a] ^ s1_dt[smgd_pkg::DT_W-1];
          s3_phi[g][a]  <= smgd_pkg::PHI_W'(s2_vmag[g][a])
                         * smgd_pkg::PHI_W'(s2_ad[smgd_pkg::TIME_WIDTH-1:smgd_pkg::TIME_FRAC]);
          s3_plo[g][a]  <= smgd_pkg::PLO_W'(s2_vmag[g][a])
                         * smgd_pkg::PLO_W'(s2_ad[smgd_pkg::TIME_FRAC-1:0]);
          s3_mneg[g][a] <= s2_mneg[g][a];
          s4_m[g][a]    <= s3_phi[g][a] + smgd_pkg::MOT_W'(
                             (s3_plo[g][a] + smgd_pkg::ROUND_HALF) >> smgd_pkg::TIME_FRAC);
          s4_mneg[g][a] <= s3_mneg[g][a];
          s5_err[g][a]  <= s4_mneg[g][a] ? pd_ext[a] + m_ext[g][a] : pd_ext[a] - m_ext[g][a];
          s6_mag[g][a]  <= err_mag[g][a][smgd_pkg::MAG_W-1:0];
          s7_sq[g][a]   <= smgd_pkg::SQ_W'(s6_mag[g][a]) * smgd_pkg::SQ_W'(s6_mag[g][a]);
        end
        s6_huge[g] <= (|err_mag[g][0][smgd_pkg::ERR_W-1:smgd_pkg::MAG_W])
                   || (|err_mag[g][1][smgd_pkg::ERR_W-1:smgd_pkg::MAG_W]);
        s7_huge[g] <= s6_huge[g];
        s8_sum[g]  <= smgd_pkg::SUM_W'(s7_sq[g][0]) + smgd_pkg::SUM_W'(s7_sq[g][1]);
        s8_huge[g] <= s7_huge[g];
      end
    end
  end

  assign fwd_in = {s8_valid, s8_huge[0]};
  assign bwd_in = {s8_valid, s8_huge[1]};

  smgd_sqrt u_fwd_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag_in   (fwd_in),
    .radicand (s8_sum[0]),
    .tag_out  (fwd_tag),
    .root     (fwd_root)
  );

  smgd_sqrt u_bwd_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag_in   (bwd_in),
    .radicand (s8_sum[1]),
    .tag_out  (bwd_tag),
    .root     (bwd_root)
  );

  always_comb begin
    gap_f    = (fwd_tag.huge || fwd_root > smgd_pkg::GAP_CAP) ? smgd_pkg::GAP_CAP : fwd_root;
    gap_b    = (bwd_tag.huge || bwd_root > smgd_pkg::GAP_CAP) ? smgd_pkg::GAP_CAP : bwd_root;
    mean_sum = {1'b0, gap_f} + {1'b0, gap_b} + (smgd_pkg::ROOT_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s38_mean <= mean_sum[smgd_pkg::ROOT_W:1];
    end
  end

  always_comb begin
    sat_mean   = (|s38_mean[smgd_pkg::ROOT_W-1:smgd_pkg::DIST_WIDTH]) ? smgd_pkg::DIST_MAX
                                                                      : s38_mean[smgd_pkg::DIST_WIDTH-1:0];
    sat_within = sat_mean < gate_distance;
  end

  // Output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s38_valid;
      end
    end else if (s38_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_mean   <= skid_mean;
        out_within <= skid_within;
      end else begin
        out_mean   <= sat_mean;
        out_within <= sat_within;
      end
    end else if (en) begin
      skid_mean   <= sat_mean;
      skid_within <= sat_within;
    end
  end

  assign result.valid         = out_valid;
  assign result.mean_distance = out_mean;
  assign result.within_gate   = out_within;

  `SMGD_ASSERT_IMPLY(a_lanes_in_step, clk, rst, fwd_tag.valid || bwd_tag.valid, fwd_tag.valid && bwd_tag.valid, "forward and backward root lanes out of step")
  `SMGD_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid entry held while output register empty")
  `SMGD_ASSERT_IMPLY(a_gate_below_max, clk, rst, out_valid && out_within, out_mean != smgd_pkg::DIST_MAX, "saturated distance flagged inside gate")
  `SMGD_ASSERT_NEXT(a_skid_catches, clk, rst, out_valid && !result.ready && s38_valid && en, skid_valid, "result dropped while output stalled")

endmodule
